FILE: src/kbeq_pkg.sv
// package for the knob and button event qualifier
// holds widths, register indexes, reset values and stream field layout; no dependencies
`default_nettype none

package kbeq_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int FLAG_W  = 4;

    // input tdata layout, lowest bit first
    localparam int IN_TDATA_W  = 48;
    localparam int IN_NOW_LSB  = 0;
    localparam int IN_MOVED    = 32;
    localparam int IN_CNT_LSB  = 33;
    localparam int IN_DOWN     = 41;
    localparam int IN_CLEAR    = 42;

    localparam int OUT_TDATA_W = 8;

    // event flag bit positions
    localparam int FLAG_RIGHT = 0;
    localparam int FLAG_LEFT  = 1;
    localparam int FLAG_SHORT = 2;
    localparam int FLAG_HELD  = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd1000;

    typedef enum logic [IDX_W-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_REPEAT     = 2'd2,
        REG_RESERVED   = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

FILE: src/knob_and_button_event_qualifier.sv
// knob and button event qualifier, top level
// depends on kbeq_pkg for widths, field layout and register indexes
`default_nettype none

// usage
// - s_axis carries one poll request per tick in tdata: now_ms, knob_moved,
//   knob_count, button_level_down, clear_request (see port comment)
// - m_axis returns one result request per poll: the four event flags after it
// - cfg channel writes debounce_ms (0), long_press_ms (1), repeat_ms (2);
//   other indexes are taken and dropped; cfg_ready is always high, write
//   only while no poll is in flight
// - an accepted poll lands in the input register; once the result slot is
//   free the whole update runs and loads the result register, which raises
//   tvalid; one poll per cycle sustained while m_axis_tready stays high
// - the update path is one 32-bit wrapping subtract and compare per timer,
//   all three side by side, so every poll can follow the one before
// - when m_axis_tready is low the result holds, the input register still
//   takes one more poll, then s_axis_tready drops until the result is taken
// - reset restores 50/1000/1000 ms, clears times, last count, button level
//   and flags, and empties both registers
module knob_and_button_event_qualifier
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // poll requests
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [31:0] now_ms, [32] knob_moved, [40:33] knob_count,
    // [41] button_level_down, [42] clear_request, [47:43] zero
    input  wire logic [kbeq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result requests
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] turned_right, [1] turned_left, [2] short_press, [3] long_hold, [7:4] zero
    output logic [kbeq_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [kbeq_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [kbeq_pkg::CFG_W-1:0]           cfg_data
);

    localparam int TW = kbeq_pkg::TIME_W;
    localparam int CW = kbeq_pkg::COUNT_W;

    // configuration registers
    logic [kbeq_pkg::CFG_W-1:0] debounce_reg;
    logic [kbeq_pkg::CFG_W-1:0] long_press_reg;
    logic [kbeq_pkg::CFG_W-1:0] repeat_reg;

    // input stage
    logic                        in_valid_reg;
    logic [TW-1:0]               in_now_reg;
    logic                        in_moved_reg;
    logic [CW-1:0]               in_count_reg;
    logic                        in_down_reg;
    logic                        in_clear_reg;

    // block state; flags_reg doubles as the result register
    logic [TW-1:0]               knob_time_reg, knob_time_next;
    logic [CW-1:0]               prev_count_reg, prev_count_next;
    logic [TW-1:0]               press_start_reg, press_start_next;
    logic [TW-1:0]               repeat_time_reg, repeat_time_next;
    logic                        prev_button_reg;
    logic [kbeq_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic                        out_valid_reg;

    logic                        advance;
    logic                        knob_ok;
    logic                        press_edge;
    logic                        release_edge;
    logic                        held;
    logic [TW-1:0]               knob_delta;
    logic [TW-1:0]               press_delta;
    logic [TW-1:0]               repeat_delta;

    // the poll in the input register moves on when the result slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(kbeq_pkg::OUT_TDATA_W - kbeq_pkg::FLAG_W){1'b0}}, flags_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= kbeq_pkg::DEBOUNCE_RST;
            long_press_reg <= kbeq_pkg::LONG_PRESS_RST;
            repeat_reg     <= kbeq_pkg::REPEAT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (kbeq_pkg::cfg_index_t'(cfg_index))
                kbeq_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                kbeq_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                kbeq_pkg::REG_REPEAT:     repeat_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_now_reg   <= s_axis_tdata[kbeq_pkg::IN_NOW_LSB +: TW];
            in_moved_reg <= s_axis_tdata[kbeq_pkg::IN_MOVED];
            in_count_reg <= s_axis_tdata[kbeq_pkg::IN_CNT_LSB +: CW];
            in_down_reg  <= s_axis_tdata[kbeq_pkg::IN_DOWN];
            in_clear_reg <= s_axis_tdata[kbeq_pkg::IN_CLEAR];
        end
    end

    // one poll's worth of update
    always_comb
    begin
        knob_time_next   = knob_time_reg;
        prev_count_next  = prev_count_reg;
        press_start_next = press_start_reg;
        repeat_time_next = repeat_time_reg;
        flags_next       = in_clear_reg ? '0 : flags_reg;

        // knob rotation, debounced against the last accepted change
        knob_delta = in_now_reg - knob_time_reg;
        knob_ok    = in_moved_reg && (knob_delta > {{(TW - kbeq_pkg::CFG_W){1'b0}}, debounce_reg});
        if (knob_ok)
        begin
            knob_time_next  = in_now_reg;
            prev_count_next = in_count_reg;
            if (in_count_reg > prev_count_reg)
            begin
                flags_next[kbeq_pkg::FLAG_RIGHT] = 1'b1;
            end
            else if (in_count_reg < prev_count_reg)
            begin
                flags_next[kbeq_pkg::FLAG_LEFT] = 1'b1;
            end
        end

        // fresh press restarts the hold timer and the repeat time
        press_edge   = in_down_reg && !prev_button_reg;
        release_edge = !in_down_reg && prev_button_reg;
        if (press_edge)
        begin
            press_start_next = in_now_reg;
            repeat_time_next = '0;
        end

        // held past long-press time, repeated after each repeat interval
        press_delta  = in_now_reg - press_start_next;
        repeat_delta = in_now_reg - repeat_time_next;
        held = in_down_reg
            && (press_delta > {{(TW - kbeq_pkg::CFG_W){1'b0}}, long_press_reg})
            && (repeat_delta > {{(TW - kbeq_pkg::CFG_W){1'b0}}, repeat_reg});
        if (held)
        begin
            flags_next[kbeq_pkg::FLAG_HELD] = 1'b1;
            repeat_time_next = in_now_reg;
        end

        // release: short press if under long-press time, held always drops
        if (release_edge)
        begin
            if (press_delta < {{(TW - kbeq_pkg::CFG_W){1'b0}}, long_press_reg})
            begin
                flags_next[kbeq_pkg::FLAG_SHORT] = 1'b1;
            end
            flags_next[kbeq_pkg::FLAG_HELD] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_time_reg   <= '0;
            prev_count_reg  <= '0;
            press_start_reg <= '0;
            repeat_time_reg <= '0;
            prev_button_reg <= 1'b0;
            flags_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                knob_time_reg   <= knob_time_next;
                prev_count_reg  <= prev_count_next;
                press_start_reg <= press_start_next;
                repeat_time_reg <= repeat_time_next;
                prev_button_reg <= in_down_reg;
                flags_reg       <= flags_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // state and result move only with a poll
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg) && $stable(press_start_reg) && $stable(knob_time_reg))
        else $error("state changed without a poll");

    // button level tracks the last processed poll
    a_button_track: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> prev_button_reg == $past(in_down_reg))
        else $error("previous button level not updated");

    // a poll with the button up never reports a hold
    a_no_hold_when_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_down_reg |=> !flags_reg[kbeq_pkg::FLAG_HELD])
        else $error("hold flag set with button released");

    // a write to the unused index leaves the configuration alone
    a_reserved_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == kbeq_pkg::REG_RESERVED
        |=> $stable(debounce_reg) && $stable(long_press_reg) && $stable(repeat_reg))
        else $error("reserved configuration index changed a register");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// self-checking bench for knob_and_button_event_qualifier: directed polls, then random ones
// in five runs of register settings, each result checked against a flag predictor kept here
// depends on kbeq_pkg and the knob_and_button_event_qualifier rtl
`timescale 1ns / 100ps

module tb_top;

    import kbeq_pkg::*;

    // one poll request as packed in s_axis_tdata, last field in the lowest bits
    typedef struct packed {
        logic [4:0]         pad;
        logic               clear;
        logic               down;
        logic [COUNT_W-1:0] count;
        logic               moved;
        logic [TIME_W-1:0]  now;
    } poll_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = REG_DEBOUNCE;
    logic [CFG_W-1:0]      cfg_data = '0;

    knob_and_button_event_qualifier uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // single reset at the start
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // polls waiting to be sent and flag words waiting to come back
    poll_t            pending_polls [$];
    logic [FLAG_W-1:0] expected_flags [$];
    int unsigned      mismatch_count = 0;

    // idle control per phase: steady means no gaps on that side
    bit          sender_steady = 1'b0;
    bit          receiver_steady = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_left = 0;
    int unsigned recv_draw;

    // predictor copy of the settings and the qualifier state
    logic [CFG_W-1:0]   cfg_debounce   = DEBOUNCE_RST;
    logic [CFG_W-1:0]   cfg_long_press = LONG_PRESS_RST;
    logic [CFG_W-1:0]   cfg_repeat     = REPEAT_RST;
    logic [TIME_W-1:0]  knob_time   = '0;
    logic [COUNT_W-1:0] last_count  = '0;
    logic [TIME_W-1:0]  press_time  = '0;
    logic [TIME_W-1:0]  repeat_time = '0;
    logic               btn_prev    = 1'b0;
    logic [FLAG_W-1:0]  ev_flags    = '0;

    logic [FLAG_W-1:0]  want_flags;
    string flag_name [FLAG_W] = '{"turned_right", "turned_left", "short_press", "long_hold"};

    // stimulus generator state: simulated time, encoder count, button plan
    logic [TIME_W-1:0]  stim_ms = '0;
    logic [COUNT_W-1:0] stim_count = '0;
    logic               stim_down = 1'b0;
    logic [TIME_W-1:0]  release_at = '0;

    // flag word after one poll; updates the predictor state
    function automatic logic [FLAG_W-1:0] qualify_poll(input poll_t p);
        logic [TIME_W-1:0] since_knob;
        logic [TIME_W-1:0] since_press;
        logic [TIME_W-1:0] since_repeat;
        // clear goes first so events of the same poll still show
        if (p.clear)
            ev_flags = '0;
        // knob change only counts outside the debounce window, all deltas wrap
        since_knob = p.now - knob_time;
        if (p.moved && since_knob > TIME_W'(cfg_debounce))
        begin
            knob_time = p.now;
            if (p.count > last_count)
                ev_flags[FLAG_RIGHT] = 1'b1;
            else if (p.count < last_count)
                ev_flags[FLAG_LEFT] = 1'b1;
            last_count = p.count;
        end
        // fresh press restarts the hold timer and zeroes the repeat stamp
        if (p.down && !btn_prev)
        begin
            press_time  = p.now;
            repeat_time = '0;
        end
        since_press  = p.now - press_time;
        since_repeat = p.now - repeat_time;
        if (p.down && since_press > TIME_W'(cfg_long_press) &&
            since_repeat > TIME_W'(cfg_repeat))
        begin
            ev_flags[FLAG_HELD] = 1'b1;
            repeat_time = p.now;
        end
        // release: short only if strictly under the long-press time
        if (!p.down && btn_prev)
        begin
            if (since_press < TIME_W'(cfg_long_press))
                ev_flags[FLAG_SHORT] = 1'b1;
            ev_flags[FLAG_HELD] = 1'b0;
        end
        btn_prev = p.down;
        return ev_flags;
    endfunction

    // poll request driver: one random gap drawn per item before the next, none when the sender is steady
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (pending_polls.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_polls.pop_front();
                send_gap      <= sender_steady ? 0 : $urandom_range(0, 10);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result request sink: after each taken result, a random stall is drawn, none when the receiver is steady
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_left     <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            recv_draw = receiver_steady ? 0 : $urandom_range(0, 10);
            recv_left     <= recv_draw;
            m_axis_tready <= (recv_draw == 0);
        end
        else if (recv_left > 1)
        begin
            recv_left     <= recv_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            recv_left     <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // monitor: settings writes, accepted polls and returned flag words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register writes feed the predictor's copy; index beyond two is dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:   cfg_debounce   = cfg_data;
                    REG_LONG_PRESS: cfg_long_press = cfg_data;
                    REG_REPEAT:     cfg_repeat     = cfg_data;
                    default:        ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_flags.push_back(qualify_poll(poll_t'(s_axis_tdata)));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_flags.size() == 0)
                begin
                    $error("result request with no poll waiting for it");
                    mismatch_count++;
                end
                else
                begin
                    want_flags = expected_flags.pop_front();
                    for (int f = 0; f < FLAG_W; f++)
                    begin
                        if (m_axis_tdata[f] !== want_flags[f])
                        begin
                            $error("%s expected %0d actual %0d",
                                   flag_name[f], want_flags[f], m_axis_tdata[f]);
                            mismatch_count++;
                        end
                    end
                end
            end
        end
    end

    function automatic poll_t make_poll(input logic [TIME_W-1:0] now, input logic moved,
                                        input logic [COUNT_W-1:0] count, input logic down,
                                        input logic clear);
        poll_t p;
        p = '0;
        p.now   = now;
        p.moved = moved;
        p.count = count;
        p.down  = down;
        p.clear = clear;
        return p;
    endfunction

    // one register write on the settings channel
    task automatic write_setting(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // hold off until every poll is sent and every flag word is back
    task automatic wait_flags_drained();
        while (pending_polls.size() != 0 || s_axis_tvalid || expected_flags.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random polls: mostly well-formed presses sized around the hold time,
    // knob steps of a few counts, with glitches, clears and time jumps mixed in
    task automatic queue_random_polls(input int n, input int unsigned hold_ms,
                                      input int unsigned step_max);
        poll_t             p;
        int unsigned       stride;
        int unsigned       hold;
        logic [TIME_W-1:0] remaining;
        for (int i = 0; i < n; i++)
        begin
            p = '0;
            stride = $urandom_range(0, step_max);
            if ($urandom_range(0, 39) == 0)
            begin
                // jump anywhere in the 32-bit time range, drops any press
                stim_ms   = $urandom();
                stim_down = 1'b0;
            end
            else
            begin
                remaining = release_at - stim_ms;
                if (stim_down && stride >= remaining)
                begin
                    // land the release on the planned time so boundaries are hit exactly
                    stim_ms   = release_at;
                    stim_down = 1'b0;
                end
                else
                begin
                    stim_ms += stride;
                    if (!stim_down && $urandom_range(0, 5) == 0)
                    begin
                        stim_down = 1'b1;
                        case ($urandom_range(0, 3))
                            0:       hold = (hold_ms > 0) ? hold_ms - 1 : 0;
                            1:       hold = hold_ms;
                            2:       hold = hold_ms + 1;
                            default: hold = $urandom_range(0, 3 * hold_ms + 4 * step_max);
                        endcase
                        release_at = stim_ms + hold;
                    end
                end
            end
            p.now   = stim_ms;
            p.moved = ($urandom_range(0, 2) == 0);
            if (p.moved)
            begin
                case ($urandom_range(0, 5))
                    0:       stim_count = $urandom_range(0, 255);
                    1:       ;
                    2, 3:    stim_count += $urandom_range(1, 3);
                    default: stim_count -= $urandom_range(1, 3);
                endcase
            end
            p.count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : stim_count;
            // button bounce now and then
            p.down  = ($urandom_range(0, 19) == 0) ? ~stim_down : stim_down;
            p.clear = ($urandom_range(0, 14) == 0);
            pending_polls.push_back(p);
        end
    endtask

    // write all three registers, then run a block of random polls to completion
    task automatic run_phase(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lp,
                             input logic [CFG_W-1:0] rep, input int n,
                             input int unsigned step_max, input bit send_steady,
                             input bit recv_steady);
        write_setting(REG_DEBOUNCE, deb);
        write_setting(REG_LONG_PRESS, lp);
        write_setting(REG_REPEAT, rep);
        @(negedge clk);
        sender_steady   = send_steady;
        receiver_steady = recv_steady;
        queue_random_polls(n, lp, step_max);
        wait_flags_drained();
    endtask

    // stimulus sequence
    initial
    begin
        @(posedge rst_n);
        @(negedge clk);

        // directed polls at the reset settings 50 / 1000 / 1000 ms
        pending_polls.push_back(make_poll(32'd0, 1'b0, 8'd0, 1'b0, 1'b0));
        // knob: accepted step up, change inside the window, change exactly at the window
        pending_polls.push_back(make_poll(32'd51, 1'b1, 8'd5, 1'b0, 1'b0));
        pending_polls.push_back(make_poll(32'd60, 1'b1, 8'd3, 1'b0, 1'b0));
        pending_polls.push_back(make_poll(32'd101, 1'b1, 8'd9, 1'b0, 1'b0));
        // step down, then a moved mark with the same count
        pending_polls.push_back(make_poll(32'd102, 1'b1, 8'd0, 1'b0, 1'b0));
        pending_polls.push_back(make_poll(32'd200, 1'b1, 8'd0, 1'b0, 1'b0));
        // clear together with a knob event still reports the event
        pending_polls.push_back(make_poll(32'd300, 1'b1, 8'd255, 1'b0, 1'b1));
        // debounce delta across the 32-bit wrap
        pending_polls.push_back(make_poll(32'hFFFF_FFF0, 1'b1, 8'd255, 1'b0, 1'b0));
        pending_polls.push_back(make_poll(32'h0000_0030, 1'b1, 8'd254, 1'b0, 1'b0));
        // hold: at the long-press time nothing, one past it held, repeat spacing
        pending_polls.push_back(make_poll(32'd1000, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd2000, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd2001, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd3001, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd3002, 1'b0, 8'd0, 1'b1, 1'b0));
        // long release clears held without a short press
        pending_polls.push_back(make_poll(32'd3100, 1'b0, 8'd0, 1'b0, 1'b0));
        // short press just under the long-press time
        pending_polls.push_back(make_poll(32'd4000, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd4999, 1'b0, 8'd0, 1'b0, 1'b0));
        pending_polls.push_back(make_poll(32'd5000, 1'b0, 8'd0, 1'b0, 1'b1));
        // press lasting exactly the long-press time sets neither flag
        pending_polls.push_back(make_poll(32'd6000, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd7000, 1'b0, 8'd0, 1'b0, 1'b0));
        // clear on the same poll as a short release
        pending_polls.push_back(make_poll(32'd8000, 1'b0, 8'd0, 1'b1, 1'b0));
        pending_polls.push_back(make_poll(32'd8010, 1'b0, 8'd0, 1'b0, 1'b1));
        // time at its top value with moved, down and clear set, then a release across the wrap
        pending_polls.push_back(make_poll(32'hFFFF_FFFF, 1'b1, 8'd0, 1'b1, 1'b1));
        pending_polls.push_back(make_poll(32'd5, 1'b1, 8'd170, 1'b0, 1'b0));
        wait_flags_drained();
        stim_ms = 32'd5;

        // random polls, reset settings still in place, gaps on both sides
        queue_random_polls(100, LONG_PRESS_RST, 150);
        wait_flags_drained();

        // all settings at zero plus a write to the unused index, no idling anywhere
        write_setting(REG_RESERVED, 16'hFFFF);
        run_phase(16'd0, 16'd0, 16'd0, 100, 3, 1'b1, 1'b1);
        // all settings at the top, steady sender against a stalling receiver
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 12000, 1'b1, 1'b0);
        // short windows with fast repeat, idling sender against a steady receiver
        run_phase(16'd20, 16'd200, 16'd50, 100, 40, 1'b0, 1'b1);
        // back to the reset values, gaps on both sides
        run_phase(DEBOUNCE_RST, LONG_PRESS_RST, REPEAT_RST, 100, 150, 1'b0, 1'b0);

        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
